// ===== rtl/core/csfr_pkg.sv =====
// Shared constants and types for the frame receiver.
`default_nettype none
package csfr_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int STORE_DEPTH   = PAYLOAD_DEPTH + 1;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int COUNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    localparam logic [7:0] BYTE_EXT_START = 8'hF0;
    localparam logic [7:0] BYTE_STD_START = 8'hF1;
    localparam logic [7:0] BYTE_END       = 8'hF2;
    localparam logic [7:0] BYTE_ESCAPE    = 8'hF3;
    localparam logic [7:0] ESC_MAX        = 8'h03;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_port_t;

    // frame closed and passed all checks
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] plen;
    } frame_done_t;

endpackage
`default_nettype wire

// ===== rtl/core/csfr_store.sv =====
// Frame store: one write port, one registered read port.
`default_nettype none
module csfr_store (
    input  wire logic                      aclk,
    input  wire csfr_pkg::wr_port_t        wr,
    input  wire logic                      rd_en,
    input  wire logic [csfr_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                     rd_data
);

    logic [7:0] mem [csfr_pkg::STORE_DEPTH];

    // write decoded bytes
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read; data holds while idle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/csfr_deframer.sv =====
// Start hunting, escape removal, checksum and length tracking.
`default_nettype none
module csfr_deframer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           byte_in,
    output csfr_pkg::wr_port_t        wr,
    output csfr_pkg::frame_done_t     done
);

    logic                          in_frame_reg, in_frame_next;
    logic                          esc_reg, esc_next;
    logic                          bad_reg, bad_next;
    logic [7:0]                    xor_reg, xor_next;
    logic [csfr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          store_req;
    logic [7:0]                    store_val;

    // decode one accepted item
    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        bad_next      = bad_reg;
        xor_next      = xor_reg;
        count_next    = count_reg;
        store_req     = 1'b0;
        store_val     = byte_in;
        done.valid    = 1'b0;
        done.plen     = count_reg - csfr_pkg::COUNT_W'(1);
        wr.en         = 1'b0;
        wr.addr       = count_reg[csfr_pkg::ADDR_W-1:0];
        wr.data       = byte_in;

        if (byte_valid) begin
            if (!in_frame_reg) begin
                if (byte_in inside {csfr_pkg::BYTE_EXT_START, csfr_pkg::BYTE_STD_START}) begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    bad_next      = 1'b0;
                    xor_next      = 8'h00;
                    count_next    = '0;
                end
            end else if (byte_in == csfr_pkg::BYTE_END) begin
                done.valid    = !bad_reg && !esc_reg && (count_reg != '0) && (xor_reg == 8'h00);
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                bad_next      = 1'b0;
                xor_next      = 8'h00;
                count_next    = '0;
            end else if (bad_reg) begin
                // ignore until end byte
            end else if (esc_reg) begin
                esc_next = 1'b0;
                if (byte_in > csfr_pkg::ESC_MAX) begin
                    bad_next = 1'b1;
                end else begin
                    store_req = 1'b1;
                    store_val = csfr_pkg::BYTE_EXT_START | byte_in;
                end
            end else if (byte_in == csfr_pkg::BYTE_ESCAPE) begin
                esc_next = 1'b1;
            end else begin
                store_req = 1'b1;
            end
        end

        // store decoded byte or flag overflow
        if (store_req) begin
            if (count_reg >= csfr_pkg::COUNT_W'(csfr_pkg::STORE_DEPTH)) begin
                bad_next = 1'b1;
            end else begin
                wr.en      = 1'b1;
                wr.data    = store_val;
                count_next = count_reg + csfr_pkg::COUNT_W'(1);
                xor_next   = xor_reg ^ store_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            bad_reg      <= 1'b0;
            xor_reg      <= 8'h00;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            bad_reg      <= bad_next;
            xor_reg      <= xor_next;
            count_reg    <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/csafe_frame_receiver.sv =====
// Frame receiver top level: deframer, frame store and payload emitter.
// Input: one line byte per cycle while no payload is being sent; a byte
// that closes an accepted frame takes the block out of input for the burst.
// Output: after that end byte the emitter reads each payload item from the
// store, then holds it until taken (states READ, SHOW); an empty payload
// item is valid in the cycle after that byte. Reset (aresetn low, sync) returns to hunting.
`default_nettype none
module csafe_frame_receiver (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] payload_byte
    output logic            m_tlast,   // last_of_frame
    output logic            m_tuser    // [0] empty_payload
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SHOW  = 4'b0100,
        ST_EMPTY = 4'b1000
    } emit_state_t;

    emit_state_t                    state_reg, state_next;
    logic [csfr_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [csfr_pkg::COUNT_W-1:0]   plen_reg, plen_next;
    csfr_pkg::wr_port_t             wr;
    csfr_pkg::frame_done_t          done;
    logic                           rd_en;
    logic [7:0]                     rd_data;
    logic                           at_last;

    assign s_tready = (state_reg == ST_IDLE);

    csfr_deframer u_deframer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .byte_in    (s_tdata),
        .wr         (wr),
        .done       (done)
    );

    csfr_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (csfr_pkg::ADDR_W'(idx_reg)),
        .rd_data (rd_data)
    );

    assign at_last = (csfr_pkg::COUNT_W'(idx_reg) + csfr_pkg::COUNT_W'(1)) == plen_reg;

    // sequence the payload burst
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        plen_next  = plen_reg;
        rd_en      = 1'b0;
        m_tvalid   = 1'b0;
        m_tdata    = rd_data;
        m_tlast    = 1'b0;
        m_tuser    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (done.valid) begin
                    idx_next  = '0;
                    plen_next = done.plen;
                    state_next = (done.plen == '0) ? ST_EMPTY : ST_READ;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                m_tvalid = 1'b1;
                m_tlast  = at_last;
                if (m_tready) begin
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + csfr_pkg::IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMPTY: begin
                m_tvalid = 1'b1;
                m_tdata  = 8'h00;
                m_tlast  = 1'b1;
                m_tuser  = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // burst position and length
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        plen_reg <= plen_next;
    end

endmodule
`default_nettype wire

// ===== tb/csafe_frame_receiver_tb.sv =====
// Testbench for the frame receiver: builds stuffed frames, predicts payload and checks results.
`timescale 1ns / 1ps

module csafe_frame_receiver_tb;

    localparam int TIMEOUT_NS       = 2_000_000;
    localparam int BYTES_PER_PHASE  = 100;
    localparam int TAIL_CYCLES      = 100;

    typedef logic [7:0] line_q_t[$];

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } payload_beat_t;

    typedef enum {FLAW_NONE, FLAW_BAD_SUM, FLAW_BAD_ESC, FLAW_DANGLING} flaw_t;

    // Deframer shadow: tracks line bytes and queues the payload each frame should yield
    class payload_tracker_t;
        bit            in_frame;
        bit            esc_pending;
        bit            frame_bad;
        logic [7:0]    xor_acc;
        int unsigned   decoded;
        logic [7:0]    frame_copy [csfr_pkg::STORE_DEPTH];
        payload_beat_t payload_due[$];
        int            errors;
        int            frames_closed;
        int            frames_passed;
        int            beats_checked;

        task report(input string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task drop_frame();
            in_frame    = 1'b0;
            esc_pending = 1'b0;
            frame_bad   = 1'b0;
            xor_acc     = '0;
            decoded     = 0;
        endtask

        task store_decoded(input logic [7:0] v);
            if (decoded >= csfr_pkg::STORE_DEPTH) begin
                frame_bad = 1'b1;
                return;
            end
            frame_copy[decoded] = v;
            decoded++;
            xor_acc ^= v;
        endtask

        task take_line_byte(input logic [7:0] b);
            payload_beat_t beat;
            // hunt for a start byte
            if (!in_frame) begin
                if (b == csfr_pkg::BYTE_EXT_START || b == csfr_pkg::BYTE_STD_START) begin
                    drop_frame();
                    in_frame = 1'b1;
                end
                return;
            end
            // close the frame; emit payload only if every check passed
            if (b == csfr_pkg::BYTE_END) begin
                frames_closed++;
                if (!frame_bad && !esc_pending && decoded >= 1 && xor_acc == 8'h00) begin
                    frames_passed++;
                    if (decoded == 1) begin
                        beat.data  = 8'h00;
                        beat.last  = 1'b1;
                        beat.empty = 1'b1;
                        payload_due = {payload_due, beat};
                    end else begin
                        for (int i = 0; i < decoded - 1; i++) begin
                            beat.data  = frame_copy[i];
                            beat.last  = (i == decoded - 2);
                            beat.empty = 1'b0;
                            payload_due = {payload_due, beat};
                        end
                    end
                end
                drop_frame();
                return;
            end
            if (frame_bad)
                return;
            // second half of an escape pair
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (b > csfr_pkg::ESC_MAX)
                    frame_bad = 1'b1;
                else
                    store_decoded(csfr_pkg::BYTE_EXT_START + b);
                return;
            end
            if (b == csfr_pkg::BYTE_ESCAPE) begin
                esc_pending = 1'b1;
                return;
            end
            store_decoded(b);
        endtask

        task check_payload(input logic [7:0] data, input logic last, input logic empty);
            payload_beat_t want;
            if (payload_due.size() == 0) begin
                report($sformatf("unexpected item data=%02h last=%0b empty=%0b",
                                 data, last, empty));
                return;
            end
            want = payload_due.pop_front();
            beats_checked++;
            if (last !== want.last)
                report($sformatf("last=%0b, want %0b", last, want.last));
            if (empty !== want.empty)
                report($sformatf("empty=%0b, want %0b", empty, want.empty));
            // data is don't-care on an empty-payload item
            if (!want.empty && data !== want.data)
                report($sformatf("data=%02h, want %02h", data, want.data));
        endtask
    endclass

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int tx_idle_pct  = 10;
    int rx_stall_pct = 82;
    int line_bytes   = 0;

    payload_tracker_t tracker = new();

    csafe_frame_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Track accepted items on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.take_line_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            tracker.check_payload(m_tdata, m_tlast, m_tuser);
    end

    // Stuff payload plus checksum into a line frame, optionally with a flaw
    function automatic void encode_frame(input line_q_t payload, input flaw_t flaw,
                                         output line_q_t line);
        logic [7:0] sum;
        logic [7:0] v;
        logic [7:0] bad_code;
        line_q_t    body;
        int         cut;
        sum  = '0;
        body = payload;
        foreach (payload[i]) sum ^= payload[i];
        if (flaw == FLAW_BAD_SUM)
            sum ^= 8'($urandom_range(255, 1));
        body = {body, sum};
        do bad_code = 8'($urandom_range(255, csfr_pkg::ESC_MAX + 1));
        while (bad_code == csfr_pkg::BYTE_END);
        cut  = (flaw == FLAW_BAD_ESC) ? $urandom_range(body.size() - 1) : -1;
        line = {};
        line = {line, ($urandom_range(1) ? csfr_pkg::BYTE_STD_START
                                         : csfr_pkg::BYTE_EXT_START)};
        foreach (body[i]) begin
            if (i == cut) begin
                line = {line, csfr_pkg::BYTE_ESCAPE};
                line = {line, bad_code};
            end
            v = body[i];
            // start bytes may go raw inside a frame; end and escape must be stuffed
            if (v == csfr_pkg::BYTE_END || v == csfr_pkg::BYTE_ESCAPE ||
                ((v == csfr_pkg::BYTE_EXT_START || v == csfr_pkg::BYTE_STD_START) &&
                 $urandom_range(1))) begin
                line = {line, csfr_pkg::BYTE_ESCAPE};
                line = {line, 8'(v - csfr_pkg::BYTE_EXT_START)};
            end else begin
                line = {line, v};
            end
        end
        if (flaw == FLAW_DANGLING)
            line = {line, csfr_pkg::BYTE_ESCAPE};
        line = {line, csfr_pkg::BYTE_END};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        line_bytes++;
    endtask

    task automatic send_line(input line_q_t line);
        foreach (line[i]) send_byte(line[i]);
    endtask

    task automatic send_frame(input int len, input flaw_t flaw);
        line_q_t payload;
        line_q_t line;
        // bias toward the stuffed range so escapes show up often
        repeat (len)
            payload = {payload, ($urandom_range(3) == 0 ?
                                 8'(csfr_pkg::BYTE_EXT_START +
                                    8'($urandom_range(csfr_pkg::ESC_MAX))) :
                                 8'($urandom))};
        encode_frame(payload, flaw, line);
        send_line(line);
    endtask

    task automatic send_random_traffic();
        int      pick;
        int      len;
        line_q_t noise;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(csfr_pkg::PAYLOAD_DEPTH, 9)
                                        : $urandom_range(8);
        if (pick < 70) begin
            send_frame(len, FLAW_NONE);
        end else if (pick < 78) begin
            send_frame(len, FLAW_BAD_SUM);
        end else if (pick < 84) begin
            send_frame(len, FLAW_BAD_ESC);
        end else if (pick < 89) begin
            send_frame(len, FLAW_DANGLING);
        end else if (pick < 91) begin
            send_frame(csfr_pkg::PAYLOAD_DEPTH + 1 + $urandom_range(3), FLAW_NONE);
        end else begin
            // line garbage, sometimes closed by an end byte
            repeat ($urandom_range(6, 1)) noise = {noise, 8'($urandom)};
            if ($urandom_range(1))
                noise = {noise, csfr_pkg::BYTE_END};
            send_line(noise);
        end
    endtask

    // Hold the sender until every predicted payload item has been taken
    task automatic wait_payload_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.payload_due.size() != 0);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("csafe_frame_receiver_tb: errors");
        $finish;
    end

    initial begin
        int budget_end;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: noise while hunting, including a stray end and escape
        send_line('{8'h00, 8'hFF, csfr_pkg::BYTE_END, csfr_pkg::BYTE_ESCAPE});
        // empty payload: checksum byte only
        send_line('{csfr_pkg::BYTE_STD_START, 8'h00, csfr_pkg::BYTE_END});
        // every escape code, payload F0..F3, checksum zero
        send_line('{csfr_pkg::BYTE_EXT_START, csfr_pkg::BYTE_ESCAPE, 8'h00,
                    csfr_pkg::BYTE_ESCAPE, 8'h01, csfr_pkg::BYTE_ESCAPE, 8'h02,
                    csfr_pkg::BYTE_ESCAPE, csfr_pkg::ESC_MAX, 8'h00,
                    csfr_pkg::BYTE_END});
        // raw start byte inside a frame is data
        send_line('{csfr_pkg::BYTE_EXT_START, csfr_pkg::BYTE_STD_START, 8'hFF, 8'h0E,
                    csfr_pkg::BYTE_END});
        // bad escape, dangling escape, frame with nothing decoded
        send_line('{csfr_pkg::BYTE_STD_START, csfr_pkg::BYTE_ESCAPE, 8'h04,
                    csfr_pkg::BYTE_END});
        send_line('{csfr_pkg::BYTE_EXT_START, 8'h00, csfr_pkg::BYTE_ESCAPE,
                    csfr_pkg::BYTE_END});
        send_line('{csfr_pkg::BYTE_STD_START, csfr_pkg::BYTE_END});

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 82;
                end
                1: begin
                    tx_idle_pct  = 82;
                    rx_stall_pct = 10;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            // longest payload the store holds, then one byte too many
            if (phase == 0) begin
                send_frame(csfr_pkg::PAYLOAD_DEPTH, FLAW_NONE);
                send_frame(csfr_pkg::PAYLOAD_DEPTH + 1, FLAW_NONE);
            end
            budget_end = line_bytes + BYTES_PER_PHASE;
            while (line_bytes < budget_end) send_random_traffic();
            wait_payload_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.payload_due.size() != 0)
            tracker.report($sformatf("%0d payload items never arrived",
                                     tracker.payload_due.size()));

        $display("Sent %0d line bytes in %0d frames, %0d of them passed checks;",
                 line_bytes, tracker.frames_closed, tracker.frames_passed);
        $display("checked %0d payload items under three stall/idle mixes.",
                 tracker.beats_checked);
        if (tracker.errors == 0) begin
            $display("csafe_frame_receiver_tb: clean");
        end else begin
            $display("csafe_frame_receiver_tb: errors");
        end
        $finish;
    end

endmodule
